>>> rtl/lhfe_pkg.sv
// Shared types, constants and helper functions of the LED highlight fade engine.
package lhfe_pkg;

	localparam int NUM_STRIPS     = 6;
	localparam int LEDS_PER_STRIP = 64;
	localparam int FADE_TICKS     = 40;

	localparam int STRIP_W   = 3;
	localparam int LED_W     = 6;
	localparam int LEN_W     = 7;
	localparam int CNT_W     = 8;
	localparam int COLOR_W   = 8;
	localparam int LEN_REGS  = 6;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 8;

	localparam int MEM_DEPTH = NUM_STRIPS * LEDS_PER_STRIP;
	localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	localparam int CQ_DEPTH    = 2;
	localparam int CQ_PTR_W    = 1;
	localparam int CQ_CNT_W    = 2;
	localparam int RESQ_DEPTH  = 8;
	localparam int RQ_PTR_W    = $clog2(RESQ_DEPTH);
	localparam int RQ_CNT_W    = $clog2(RESQ_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_STRIP_COUNT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HL_TICKS    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STRIP_LEN0  = 4'd2;

	localparam logic [CNT_W-1:0] HL_TICKS_RESET = 8'd250;

	localparam logic OP_HIGHLIGHT = 1'b0;
	localparam logic OP_TICK      = 1'b1;

	localparam logic [1:0] KIND_PIXEL  = 2'd0;
	localparam logic [1:0] KIND_HL_OK  = 2'd1;
	localparam logic [1:0] KIND_HL_BAD = 2'd2;
	localparam logic [1:0] KIND_IDLE   = 2'd3;

	localparam logic [1:0] CMD_HL_OK    = 2'd0;
	localparam logic [1:0] CMD_HL_BAD   = 2'd1;
	localparam logic [1:0] CMD_TICK_BAD = 2'd2;
	localparam logic [1:0] CMD_TICK     = 2'd3;

	typedef struct packed {
		logic               opcode;
		logic [STRIP_W-1:0] strip_sel;
		logic [LED_W-1:0]   led_sel;
	} in_word_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [STRIP_W-1:0] out_strip;
		logic [LED_W-1:0]   out_led;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               last;
	} out_word_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [STRIP_W-1:0] strip;
		logic [LED_W-1:0]   led;
		logic [LEN_W-1:0]   len;
	} cmd_t;

	typedef struct packed {
		logic [COLOR_W-1:0] r;
		logic [COLOR_W-1:0] g;
		logic [COLOR_W-1:0] b;
	} rgb_t;

	typedef logic [LEN_W-1:0] len_arr_t [LEN_REGS];
	typedef logic [COLOR_W-1:0] fade_lut_t [256];

	function automatic fade_lut_t build_fade_lut();
		fade_lut_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = (i < FADE_TICKS) ? COLOR_W'((255 * i) / FADE_TICKS) : '0;
		end
		return t;
	endfunction

	localparam fade_lut_t FADE_LUT = build_fade_lut();

	function automatic logic [ADDR_W-1:0] led_addr(logic [STRIP_W-1:0] s, logic [LEN_W-1:0] i);
		return ADDR_W'(int'(s) * LEDS_PER_STRIP + int'(i));
	endfunction

	// Color wheel: red to green to blue and back, driven by an 8-bit position.
	function automatic rgb_t wheel(logic [7:0] pos);
		logic [7:0] w;
		logic [7:0] w2;
		logic [7:0] w3;
		rgb_t       c;
		w  = 8'd255 - pos;
		w2 = '0;
		if (w < 8'd85) begin
			w2 = w;
		end else if (w < 8'd170) begin
			w2 = w - 8'd85;
		end else begin
			w2 = w - 8'd170;
		end
		w3 = 8'(10'(w2) * 10'd3);
		if (w < 8'd85) begin
			c.r = 8'd255 - w3;
			c.g = '0;
			c.b = w3;
		end else if (w < 8'd170) begin
			c.r = '0;
			c.g = w3;
			c.b = 8'd255 - w3;
		end else begin
			c.r = w3;
			c.g = 8'd255 - w3;
			c.b = '0;
		end
		return c;
	endfunction

endpackage

>>> rtl/led_highlight_fade_engine_core.sv
// Top level of the LED highlight fade engine: configuration registers, front, back and result queue.
//
//   Channel   Handshake          Payload
//   input     push / full        item   (opcode, strip_sel, led_sel)
//   result    pop / empty        result (kind, out_strip, out_led, red, green, blue, last)
//   config    cfg_we             cfg_idx, cfg_data
//
// A highlight request or a tick on an invalid strip puts its single word on the result ports once
// the back takes it from the command queue. A tick walks the strip at one LED per cycle, while the
// result queue has room, through the read-modify-write pipeline of the single count memory.
// After reset the count memory, all 384 words of it, is cleared, and full stays high for that pass.
// The walk pauses whenever the eight-word result queue could not take its words, and up to two
// classified words wait between the front and the back.
module led_highlight_fade_engine_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  lhfe_pkg::in_word_t              item,
	input  logic                            pop,
	output logic                            empty,
	output lhfe_pkg::out_word_t             result,
	input  logic                            cfg_we,
	input  logic [lhfe_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [lhfe_pkg::CFG_DAT_W-1:0]  cfg_data
);
	import lhfe_pkg::*;

	logic [STRIP_W-1:0]  strip_count_q;
	logic [CNT_W-1:0]    highlight_ticks_q;
	len_arr_t            strip_len_q;
	logic                cmd_valid;
	cmd_t                cmd;
	logic                cmd_take;
	logic [RQ_CNT_W-1:0] res_count;
	logic                res_push;
	out_word_t           res_word;
	logic                clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_count_q     <= '0;
			highlight_ticks_q <= HL_TICKS_RESET;
			for (int k = 0; k < LEN_REGS; k++) begin
				strip_len_q[k] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_idx == REG_STRIP_COUNT) begin
				strip_count_q <= cfg_data[STRIP_W-1:0];
			end
			if (cfg_idx == REG_HL_TICKS) begin
				highlight_ticks_q <= cfg_data[CNT_W-1:0];
			end
			for (int k = 0; k < LEN_REGS; k++) begin
				if (cfg_idx == REG_STRIP_LEN0 + CFG_IDX_W'(k)) begin
					strip_len_q[k] <= cfg_data[LEN_W-1:0];
				end
			end
		end
	end

	lhfe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.hold        (clearing),
		.push        (push),
		.full        (full),
		.item        (item),
		.strip_count (strip_count_q),
		.strip_len   (strip_len_q),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_take    (cmd_take)
	);

	lhfe_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd             (cmd),
		.cmd_take        (cmd_take),
		.highlight_ticks (highlight_ticks_q),
		.res_count       (res_count),
		.res_push        (res_push),
		.res_word        (res_word),
		.clearing        (clearing)
	);

	lhfe_resq u_resq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (res_push),
		.wr_word (res_word),
		.count   (res_count),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

`ifndef ASSERT_OFF
	a_resq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (res_count < RQ_CNT_W'(RESQ_DEPTH)))
		else $error("result queue written while full");

	a_take_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid)
		else $error("command taken from an empty queue");

	a_single_word_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && (res_word.kind != KIND_PIXEL)) |-> res_word.last)
		else $error("non-pixel result word without last");

	a_no_cmd_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !cmd_take && !res_push)
		else $error("work done during the clearing pass");
`endif

endmodule

>>> rtl/lhfe_front.sv
// Front end: accepts input words, classifies them against the configuration, queues commands.
module lhfe_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          hold,
	input  logic                          push,
	output logic                          full,
	input  lhfe_pkg::in_word_t            item,
	input  logic [lhfe_pkg::STRIP_W-1:0]  strip_count,
	input  lhfe_pkg::len_arr_t            strip_len,
	output logic                          cmd_valid,
	output lhfe_pkg::cmd_t                cmd,
	input  logic                          cmd_take
);
	import lhfe_pkg::*;

	cmd_t                cq_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wp_q;
	logic [CQ_PTR_W-1:0] rp_q;
	logic [CQ_CNT_W-1:0] cnt_q;
	logic                accept;
	logic                strip_ok;
	logic [LEN_W-1:0]    len;
	cmd_t                cls;

	always_comb begin
		strip_ok = (item.strip_sel < strip_count) && (int'(item.strip_sel) < NUM_STRIPS);
		len = '0;
		for (int k = 0; k < LEN_REGS; k++) begin
			if ((int'(item.strip_sel) == k) && (k < NUM_STRIPS)) begin
				len = (int'(strip_len[k]) > LEDS_PER_STRIP) ? LEN_W'(LEDS_PER_STRIP)
									    : strip_len[k];
			end
		end
		cls.strip = item.strip_sel;
		cls.led   = item.led_sel;
		cls.len   = len;
		if (item.opcode == OP_HIGHLIGHT) begin
			cls.op = (strip_ok && ({1'b0, item.led_sel} < len)) ? CMD_HL_OK : CMD_HL_BAD;
		end else begin
			cls.op = strip_ok ? CMD_TICK : CMD_TICK_BAD;
		end
	end

	assign full      = (cnt_q == CQ_CNT_W'(CQ_DEPTH)) || hold;
	assign accept    = push && !full;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = cq_q[rp_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			cq_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (accept) begin
				wp_q <= wp_q + 1'b1;
			end
			if (cmd_take) begin
				rp_q <= rp_q + 1'b1;
			end
			case ({accept, cmd_take})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/lhfe_back.sv
// Back end: count memory, highlight loads and the pipelined strip walk that makes pixel words.
module lhfe_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	input  lhfe_pkg::cmd_t                 cmd,
	output logic                           cmd_take,
	input  logic [lhfe_pkg::CNT_W-1:0]     highlight_ticks,
	input  logic [lhfe_pkg::RQ_CNT_W-1:0]  res_count,
	output logic                           res_push,
	output lhfe_pkg::out_word_t            res_word,
	output logic                           clearing
);
	import lhfe_pkg::*;

	localparam int SUM_W = RQ_CNT_W + 2;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;

	logic [CNT_W-1:0]   mem [MEM_DEPTH];
	logic [1:0]         state_q;
	logic [ADDR_W-1:0]  clr_q;
	logic [STRIP_W-1:0] strip_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   idx_q;

	logic               v_s1;
	logic [LEN_W-1:0]   led_s1;
	logic [CNT_W-1:0]   rdata_s1;

	logic               v_s2;
	logic [LED_W-1:0]   led_s2;
	rgb_t               rgb_s2;
	logic [COLOR_W-1:0] br_s2;
	logic               fade_s2;
	logic               black_s2;

	logic               held_v_q;
	out_word_t          held_q;

	logic               mem_we;
	logic [ADDR_W-1:0]  mem_wa;
	logic [CNT_W-1:0]   mem_wd;
	logic               issue;
	logic               finish;
	logic               room;
	logic               credit_ok;
	logic [SUM_W-1:0]   need;
	logic               emit_s1;
	rgb_t               faded;
	out_word_t          pix;

	assign clearing = (state_q == ST_CLEAR);
	assign emit_s1  = v_s1 && (rdata_s1 != '0);
	assign room     = res_count < RQ_CNT_W'(RESQ_DEPTH);
	assign need     = SUM_W'(res_count) + SUM_W'(v_s1) + SUM_W'(v_s2) + SUM_W'(held_v_q)
			  + SUM_W'(1);
	assign credit_ok = need <= SUM_W'(RESQ_DEPTH);

	always_comb begin
		faded.r = 8'(({8'd0, rgb_s2.r} * {8'd0, br_s2}) >> 8);
		faded.g = 8'(({8'd0, rgb_s2.g} * {8'd0, br_s2}) >> 8);
		faded.b = 8'(({8'd0, rgb_s2.b} * {8'd0, br_s2}) >> 8);
		pix.kind      = KIND_PIXEL;
		pix.out_strip = strip_q;
		pix.out_led   = led_s2;
		pix.last      = 1'b0;
		if (black_s2) begin
			pix.red   = '0;
			pix.green = '0;
			pix.blue  = '0;
		end else if (fade_s2) begin
			pix.red   = faded.r;
			pix.green = faded.g;
			pix.blue  = faded.b;
		end else begin
			pix.red   = rgb_s2.r;
			pix.green = rgb_s2.g;
			pix.blue  = rgb_s2.b;
		end
	end

	always_comb begin
		mem_we   = 1'b0;
		mem_wa   = '0;
		mem_wd   = '0;
		issue    = 1'b0;
		finish   = 1'b0;
		cmd_take = 1'b0;
		res_push = 1'b0;
		res_word = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
			end
			ST_IDLE: begin
				if (cmd_valid && room) begin
					cmd_take           = 1'b1;
					res_word.out_strip = cmd.strip;
					res_word.out_led   = cmd.led;
					res_word.last      = 1'b1;
					case (cmd.op)
						CMD_HL_OK: begin
							mem_we        = 1'b1;
							mem_wa        = led_addr(cmd.strip, {1'b0, cmd.led});
							mem_wd        = highlight_ticks;
							res_push      = 1'b1;
							res_word.kind = KIND_HL_OK;
						end
						CMD_HL_BAD: begin
							res_push      = 1'b1;
							res_word.kind = KIND_HL_BAD;
						end
						CMD_TICK_BAD: begin
							res_push         = 1'b1;
							res_word.kind    = KIND_IDLE;
							res_word.out_led = '0;
						end
						default: begin
							res_push = 1'b0;
						end
					endcase
				end
			end
			ST_WALK: begin
				issue = (idx_q < len_q) && credit_ok;
				if (emit_s1) begin
					mem_we = 1'b1;
					mem_wa = led_addr(strip_q, led_s1);
					mem_wd = rdata_s1 - 1'b1;
				end
				if (v_s2) begin
					res_push = held_v_q;
					res_word = held_q;
				end else if ((idx_q == len_q) && !v_s1 && room) begin
					finish   = 1'b1;
					res_push = 1'b1;
					if (held_v_q) begin
						res_word      = held_q;
						res_word.last = 1'b1;
					end else begin
						res_word.kind      = KIND_IDLE;
						res_word.out_strip = strip_q;
						res_word.last      = 1'b1;
					end
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (issue) begin
			rdata_s1 <= mem[led_addr(strip_q, idx_q)];
		end
	end

	always_ff @(posedge clk) begin
		led_s1   <= idx_q;
		led_s2   <= led_s1[LED_W-1:0];
		rgb_s2   <= wheel({rdata_s1[5:0], 2'b00});
		br_s2    <= FADE_LUT[rdata_s1];
		fade_s2  <= rdata_s1 < CNT_W'(FADE_TICKS);
		black_s2 <= rdata_s1 == CNT_W'(1);
		if (v_s2) begin
			held_q <= pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			strip_q  <= '0;
			len_q    <= '0;
			idx_q    <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			held_v_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= emit_s1;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(MEM_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_take && (cmd.op == CMD_TICK)) begin
						state_q <= ST_WALK;
						strip_q <= cmd.strip;
						len_q   <= cmd.len;
						idx_q   <= '0;
					end
				end
				ST_WALK: begin
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (v_s2) begin
						held_v_q <= 1'b1;
					end
					if (finish) begin
						held_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/lhfe_resq.sv
// Result queue: holds finished result words until the consumer pops them.
module lhfe_resq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr,
	input  lhfe_pkg::out_word_t            wr_word,
	output logic [lhfe_pkg::RQ_CNT_W-1:0]  count,
	input  logic                           pop,
	output logic                           empty,
	output lhfe_pkg::out_word_t            result
);
	import lhfe_pkg::*;

	out_word_t           q_q [RESQ_DEPTH];
	logic [RQ_PTR_W-1:0] wp_q;
	logic [RQ_PTR_W-1:0] rp_q;
	logic [RQ_CNT_W-1:0] cnt_q;
	logic                take;

	assign count  = cnt_q;
	assign empty  = (cnt_q == '0);
	assign take   = pop && !empty;
	assign result = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			q_q[wp_q] <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (take) begin
				rp_q <= rp_q + 1'b1;
			end
			case ({wr, take})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
